FILE: hw/rtl/sobel_pkg.sv
// Shared types, constants and helpers for the Sobel edge threshold block.
package sobel_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int PIXEL_BITS = 8;

    localparam int MAX_HEIGHT = 2048;
    localparam int MIN_DIM    = 3;

    // Field and register widths
    localparam int THR_W   = 11;
    localparam int CFG_W   = 12;
    localparam int POS_W   = 11;
    localparam int ROW_W   = 12;
    localparam int ADDR_W  = $clog2(MAX_WIDTH);
    localparam int DIM_W   = (ADDR_W + 1 > CFG_W) ? ADDR_W + 1 : CFG_W;
    localparam int SUM_W   = PIXEL_BITS + 2;
    localparam int MAG_W   = PIXEL_BITS + 3;
    localparam int CMP_W   = (MAG_W > THR_W) ? MAG_W : THR_W;

    // Register map
    localparam int REG_IDX_W = 2;
    localparam logic [REG_IDX_W-1:0] REG_EDGE_THRESHOLD = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH    = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT   = 2'd2;

    localparam logic [THR_W-1:0] RST_EDGE_THRESHOLD = THR_W'(100);
    localparam logic [CFG_W-1:0] RST_IMAGE_WIDTH    = CFG_W'(640);
    localparam logic [CFG_W-1:0] RST_IMAGE_HEIGHT   = CFG_W'(480);

    // Queue between front and back
    localparam int WQ_DEPTH = 4;
    localparam int WQ_PTR_W = $clog2(WQ_DEPTH);
    localparam int WQ_CNT_W = $clog2(WQ_DEPTH + 1);

    // Result queue
    localparam int OQ_DEPTH = 4;
    localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
    localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

    typedef struct packed {
        logic             result_valid;
        logic             is_edge;
        logic             on_border;
        logic [POS_W-1:0] pixel_row;
        logic [POS_W-1:0] pixel_column;
    } t_result;

    typedef struct packed {
        logic [ADDR_W-1:0]     addr;
        logic [PIXEL_BITS-1:0] pix;
        t_result               info;
    } t_work;

    function automatic logic [SUM_W-1:0] abs_diff(input logic [SUM_W-1:0] a,
                                                   input logic [SUM_W-1:0] b);
        return (a >= b) ? a - b : b - a;
    endfunction

    function automatic logic [SUM_W-1:0] weighted_sum(input logic [PIXEL_BITS-1:0] a,
                                                       input logic [PIXEL_BITS-1:0] b,
                                                       input logic [PIXEL_BITS-1:0] c);
        return SUM_W'(a) + {1'b0, b, 1'b0} + SUM_W'(c);
    endfunction

endpackage

FILE: hw/rtl/sobel_edge_threshold_top.sv
// Requests pass the request queue, the line store read and the window stage.
// Throughput: one pixel per clock unless stalled; the line store is one memory
// read and written once per cycle, with window and magnitude test one stage on.
// Reset (synchronous, active low) empties both queues, clears the position
// counters and window and restores the registers; the line store is not cleared.
module sobel_edge_threshold_top import sobel_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic [PIXEL_BITS-1:0] i_pixel_value,
    input  logic                  i_frame_start,
    input  logic                  i_padding,
    output logic                  empty,
    input  logic                  pop,
    output logic                  o_result_valid,
    output logic                  o_is_edge,
    output logic                  o_on_border,
    output logic [POS_W-1:0]      o_pixel_row,
    output logic [POS_W-1:0]      o_pixel_column,
    input  logic                  i_cfg_we,
    input  logic [REG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_W-1:0]      i_cfg_data
);

    logic [THR_W-1:0] r_edge_threshold;
    logic [CFG_W-1:0] r_image_width;
    logic [CFG_W-1:0] r_image_height;

    logic    q_full, q_empty, q_push, q_pop;
    t_work   front_work, q_head;
    t_result result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_edge_threshold <= RST_EDGE_THRESHOLD;
            r_image_width    <= RST_IMAGE_WIDTH;
            r_image_height   <= RST_IMAGE_HEIGHT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_EDGE_THRESHOLD: r_edge_threshold <= i_cfg_data[THR_W-1:0];
                REG_IMAGE_WIDTH:    r_image_width    <= i_cfg_data;
                REG_IMAGE_HEIGHT:   r_image_height   <= i_cfg_data;
                default: begin
                    // drop writes to unknown registers
                end
            endcase
        end
    end

    sobel_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .i_pixel_value  (i_pixel_value),
        .i_frame_start  (i_frame_start),
        .i_padding      (i_padding),
        .i_image_width  (r_image_width),
        .i_image_height (r_image_height),
        .i_q_full       (q_full),
        .o_full         (full),
        .o_q_push       (q_push),
        .o_work         (front_work)
    );

    sobel_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (front_work),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_head  (q_head)
    );

    sobel_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_empty        (q_empty),
        .i_head           (q_head),
        .o_q_pop          (q_pop),
        .i_edge_threshold (r_edge_threshold),
        .i_pop            (pop),
        .o_empty          (empty),
        .o_result         (result)
    );

    assign o_result_valid = result.result_valid;
    assign o_is_edge      = result.is_edge;
    assign o_on_border    = result.on_border;
    assign o_pixel_row    = result.pixel_row;
    assign o_pixel_column = result.pixel_column;

endmodule

FILE: hw/rtl/sobel_front.sv
// Front end: position counters and classification of each incoming pixel.
module sobel_front import sobel_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  logic [PIXEL_BITS-1:0] i_pixel_value,
    input  logic                  i_frame_start,
    input  logic                  i_padding,
    input  logic [CFG_W-1:0]      i_image_width,
    input  logic [CFG_W-1:0]      i_image_height,
    input  logic                  i_q_full,
    output logic                  o_full,
    output logic                  o_q_push,
    output t_work                 o_work
);

    logic [ADDR_W-1:0] r_col, n_col;
    logic [ROW_W-1:0]  r_row, n_row;

    logic [ADDR_W-1:0] c;
    logic [ROW_W-1:0]  r;
    logic [DIM_W-1:0]  w, h, pr, pc, c_inc;
    logic              c_nz, valid_raw, valid, border, accept;

    assign accept   = i_push && !i_q_full;
    assign o_full   = i_q_full;
    assign o_q_push = accept;

    always_comb begin
        // clamp geometry to the supported range
        if (DIM_W'(i_image_width) < DIM_W'(MIN_DIM)) begin
            w = DIM_W'(MIN_DIM);
        end else if (DIM_W'(i_image_width) > DIM_W'(MAX_WIDTH)) begin
            w = DIM_W'(MAX_WIDTH);
        end else begin
            w = DIM_W'(i_image_width);
        end
        if (DIM_W'(i_image_height) < DIM_W'(MIN_DIM)) begin
            h = DIM_W'(MIN_DIM);
        end else if (DIM_W'(i_image_height) > DIM_W'(MAX_HEIGHT)) begin
            h = DIM_W'(MAX_HEIGHT);
        end else begin
            h = DIM_W'(i_image_height);
        end

        c = i_frame_start ? '0 : r_col;
        r = i_frame_start ? '0 : r_row;

        // the result belongs to the pixel one row up and one column left
        c_nz      = (c != '0);
        valid_raw = c_nz ? (r != '0) : (r >= ROW_W'(2));
        pr        = c_nz ? DIM_W'(r) - DIM_W'(1) : DIM_W'(r) - DIM_W'(2);
        pc        = c_nz ? DIM_W'(c) - DIM_W'(1) : w - DIM_W'(1);
        valid     = valid_raw && (pr < h) && (pc < w);
        border    = valid && ((pr == '0) || (pr == h - DIM_W'(1)) ||
                              (pc == '0) || (pc == w - DIM_W'(1)));

        o_work.addr              = c;
        o_work.pix               = i_padding ? '0 : i_pixel_value;
        o_work.info.result_valid = valid;
        o_work.info.is_edge      = 1'b0;
        o_work.info.on_border    = border;
        o_work.info.pixel_row    = valid ? POS_W'(pr) : '0;
        o_work.info.pixel_column = valid ? POS_W'(pc) : '0;

        // advance the raster position
        c_inc = DIM_W'(c) + DIM_W'(1);
        n_col = r_col;
        n_row = r_row;
        if (accept) begin
            if (c_inc >= w) begin
                n_col = '0;
                n_row = (r == '1) ? r : r + ROW_W'(1);
            end else begin
                n_col = ADDR_W'(c_inc);
                n_row = r;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

endmodule

FILE: hw/rtl/sobel_queue.sv
// Short queue of classified requests between the front and back ends.
module sobel_queue import sobel_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_work i_item,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_empty,
    output t_work o_head
);

    t_work               r_slot [WQ_DEPTH];
    logic [WQ_PTR_W-1:0] r_wp, r_rp;
    logic [WQ_CNT_W-1:0] r_cnt;
    logic                do_push, do_pop;

    assign o_full  = (r_cnt == WQ_CNT_W'(WQ_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_slot[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == WQ_PTR_W'(WQ_DEPTH - 1)) ? '0 : r_wp + WQ_PTR_W'(1);
            end
            if (do_pop) begin
                r_rp <= (r_rp == WQ_PTR_W'(WQ_DEPTH - 1)) ? '0 : r_rp + WQ_PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + WQ_CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - WQ_CNT_W'(1);
            end
        end
    end

endmodule

FILE: hw/rtl/sobel_back.sv
// Back end: line store, 3x3 window, Sobel magnitude test and result queue.
module sobel_back import sobel_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_empty,
    input  t_work            i_head,
    output logic             o_q_pop,
    input  logic [THR_W-1:0] i_edge_threshold,
    input  logic             i_pop,
    output logic             o_empty,
    output t_result          o_result
);

    // one entry holds the upper and middle line pixels of a column
    logic [2*PIXEL_BITS-1:0] mem [MAX_WIDTH];
    logic [2*PIXEL_BITS-1:0] r_rd;

    logic                    r_s1_v, r_s2_v;
    t_work                   r_s1, r_s2;
    logic [PIXEL_BITS-1:0]   r_s2_top;
    logic [PIXEL_BITS-1:0]   r_win [9];

    t_result                 r_oq [OQ_DEPTH];
    logic [OQ_PTR_W-1:0]     r_owp, r_orp;
    logic [OQ_CNT_W-1:0]     r_ocnt;

    logic [PIXEL_BITS-1:0]   top, mid;
    logic                    issue, oq_pop;
    logic [OQ_CNT_W:0]       in_flight;
    logic [SUM_W-1:0]        s_left, s_right, s_top, s_bot, gx, gy;
    logic [MAG_W-1:0]        mag;
    t_result                 res;

    // issue only when the result queue has room for everything in flight
    assign in_flight = (OQ_CNT_W + 1)'(r_ocnt) + (OQ_CNT_W + 1)'(r_s1_v)
                     + (OQ_CNT_W + 1)'(r_s2_v);
    assign issue     = !i_q_empty && (in_flight < (OQ_CNT_W + 1)'(OQ_DEPTH));
    assign o_q_pop   = issue;

    // forward the write made at the edge the read was taken
    always_comb begin
        if (r_s2_v && (r_s2.addr == r_s1.addr)) begin
            top = r_s2_top;
            mid = r_s2.pix;
        end else begin
            top = r_rd[2*PIXEL_BITS-1:PIXEL_BITS];
            mid = r_rd[PIXEL_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_v) begin
            mem[r_s1.addr] <= {mid, r_s1.pix};
        end
        r_rd <= mem[i_head.addr];
    end

    always_ff @(posedge i_clk) begin
        r_s1     <= i_head;
        r_s2     <= r_s1;
        r_s2_top <= mid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            for (int k = 0; k < 9; k++) begin
                r_win[k] <= '0;
            end
        end else begin
            r_s1_v <= issue;
            r_s2_v <= r_s1_v;
            if (r_s1_v) begin
                for (int k = 0; k < 3; k++) begin
                    r_win[k*3]     <= r_win[k*3 + 1];
                    r_win[k*3 + 1] <= r_win[k*3 + 2];
                end
                r_win[2] <= top;
                r_win[5] <= mid;
                r_win[8] <= r_s1.pix;
            end
        end
    end

    // gradient magnitude of the window now held
    always_comb begin
        s_left  = weighted_sum(r_win[0], r_win[3], r_win[6]);
        s_right = weighted_sum(r_win[2], r_win[5], r_win[8]);
        s_top   = weighted_sum(r_win[0], r_win[1], r_win[2]);
        s_bot   = weighted_sum(r_win[6], r_win[7], r_win[8]);
        gx      = abs_diff(s_right, s_left);
        gy      = abs_diff(s_top, s_bot);
        mag     = MAG_W'(gx) + MAG_W'(gy);
        res         = r_s2.info;
        res.is_edge = r_s2.info.result_valid && !r_s2.info.on_border &&
                      (CMP_W'(mag) > CMP_W'(i_edge_threshold));
    end

    assign o_empty  = (r_ocnt == '0);
    assign o_result = r_oq[r_orp];
    assign oq_pop   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (r_s2_v) begin
            r_oq[r_owp] <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owp  <= '0;
            r_orp  <= '0;
            r_ocnt <= '0;
        end else begin
            if (r_s2_v) begin
                r_owp <= (r_owp == OQ_PTR_W'(OQ_DEPTH - 1)) ? '0 : r_owp + OQ_PTR_W'(1);
            end
            if (oq_pop) begin
                r_orp <= (r_orp == OQ_PTR_W'(OQ_DEPTH - 1)) ? '0 : r_orp + OQ_PTR_W'(1);
            end
            if (r_s2_v && !oq_pop) begin
                r_ocnt <= r_ocnt + OQ_CNT_W'(1);
            end else if (oq_pop && !r_s2_v) begin
                r_ocnt <= r_ocnt - OQ_CNT_W'(1);
            end
        end
    end

endmodule

FILE: hw/rtl/sobel_checker.sv
// Port-level checks for the Sobel edge threshold block, bound to the top level.
module sobel_checker import sobel_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  full,
    input logic                  empty,
    input logic                  pop,
    input logic                  o_result_valid,
    input logic                  o_is_edge,
    input logic                  o_on_border,
    input logic [POS_W-1:0]      o_pixel_row,
    input logic [POS_W-1:0]      o_pixel_column
);

    // reset leaves no result waiting and room for a request
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> empty && !full)
        else $error("queues not cleared by reset");

    // a result with no frame pixel behind it carries all zero fields
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !o_result_valid |->
            !o_is_edge && !o_on_border && (o_pixel_row == '0) && (o_pixel_column == '0))
        else $error("invalid result with non-zero fields");

    // border pixels are never reported as edges
    a_border_no_edge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_on_border |-> o_result_valid && !o_is_edge)
        else $error("border pixel marked as edge");

    // a waiting result holds until it is taken
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_pixel_row) && $stable(o_pixel_column)
            && $stable(o_is_edge) && $stable(o_result_valid))
        else $error("waiting result changed before it was taken");

endmodule

bind sobel_edge_threshold_top sobel_checker u_sobel_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .full           (full),
    .empty          (empty),
    .pop            (pop),
    .o_result_valid (o_result_valid),
    .o_is_edge      (o_is_edge),
    .o_on_border    (o_on_border),
    .o_pixel_row    (o_pixel_row),
    .o_pixel_column (o_pixel_column)
);
